// ===== sv/bat_lvl_pkg.sv =====
// Shared types, widths and discharge-curve constants for the battery level block.
package bat_lvl_pkg;

  // Field widths
  localparam int MV_W  = 13;  // battery voltage, mV
  localparam int LVL_W = 7;   // charge level, percent

  // Curve shape
  localparam int CURVE_N = 12;          // points on the discharge curve
  localparam int SEG_N   = CURVE_N - 1; // segments between points
  localparam int SEG_W   = 4;           // indexes CURVE_N points
  localparam int OFS_W   = 8;           // offset into a segment, widest span 150 mV
  localparam int RCP_W   = 14;          // scaled rise/span factor
  localparam int RCP_SH  = 16;          // fraction bits of that factor
  localparam int QUO_W   = 4;           // interpolated step, at most 10
  localparam int PRD_W   = OFS_W + RCP_W;

  // Curve points, top first
  localparam logic [MV_W-1:0] CURVE_MV [CURVE_N] = '{
    13'd4200, 13'd4100, 13'd4000, 13'd3920, 13'd3850, 13'd3780,
    13'd3720, 13'd3660, 13'd3580, 13'd3480, 13'd3350, 13'd3200
  };

  localparam logic [LVL_W-1:0] CURVE_LVL [CURVE_N] = '{
    7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50,
    7'd40,  7'd30, 7'd20, 7'd10, 7'd5,  7'd0
  };

  // ceil(rise * 2^16 / span) per segment. Offsets stay below 150, so the
  // rounding error is under 1/150 of a step and the floor is exact.
  localparam logic [RCP_W-1:0] SEG_RCP [SEG_N] = '{
    14'd6554, 14'd6554, 14'd8192, 14'd9363, 14'd9363, 14'd10923,
    14'd10923, 14'd8192, 14'd6554, 14'd2521, 14'd2185
  };

  // Segment lookup result handed to the interpolator
  typedef struct packed {
    logic             above_top;   // at or over the top point: full
    logic             below_bot;   // under the bottom point: empty
    logic [SEG_W-1:0] seg;         // segment index, top segment is 0
    logic [OFS_W-1:0] ofs;         // voltage above the segment's lower point
    logic [LVL_W-1:0] lo_lvl;      // level at the segment's lower point
  } seg_sel_t;

endpackage

// ===== sv/bat_lvl_seg.sv =====
// Segment finder: picks the curve segment holding a voltage and the offset into it.
module bat_lvl_seg (
  input  logic [bat_lvl_pkg::MV_W-1:0] mv,
  output bat_lvl_pkg::seg_sel_t        sel
);
  import bat_lvl_pkg::*;

  logic [SEG_W-1:0] seg;
  logic [SEG_W-1:0] lo_idx;
  logic [OFS_W-1:0] diff;

  // First segment from the top whose lower point is at or under the voltage
  always_comb begin
    seg = '0;
    for (int k = SEG_N - 1; k >= 0; k--) begin
      if (mv >= CURVE_MV[k + 1]) begin
        seg = SEG_W'(k);
      end
    end
  end

  assign lo_idx = seg + SEG_W'(1);
  assign diff   = OFS_W'(mv - CURVE_MV[lo_idx]);

  // Pack up the lookup
  always_comb begin
    sel.above_top = (mv >= CURVE_MV[0]);
    sel.below_bot = (mv <  CURVE_MV[CURVE_N - 1]);
    sel.seg       = seg;
    sel.ofs       = diff;
    sel.lo_lvl    = CURVE_LVL[lo_idx];
  end

endmodule

// ===== sv/bat_lvl_interp.sv =====
// Interpolator: scales the segment offset by rise/span and adds the lower level.
module bat_lvl_interp (
  input  bat_lvl_pkg::seg_sel_t         sel,
  output logic [bat_lvl_pkg::LVL_W-1:0] level
);
  import bat_lvl_pkg::*;

  logic [PRD_W-1:0] prod;
  logic [QUO_W-1:0] step;

  // Fixed-point multiply stands in for the per-segment constant division
  assign prod = PRD_W'(sel.ofs) * PRD_W'(SEG_RCP[sel.seg]);
  assign step = prod[RCP_SH +: QUO_W];

  // Clamp ends of the curve, otherwise lower level plus the step
  always_comb begin
    priority if (sel.above_top) begin
      level = CURVE_LVL[0];
    end else if (sel.below_bot) begin
      level = CURVE_LVL[CURVE_N - 1];
    end else begin
      level = sel.lo_lvl + LVL_W'(step);
    end
  end

endmodule

// ===== sv/battery_level_from_voltage.sv =====
// Top level: battery voltage to charge percentage, input register and result register.
//
//   channel  direction  beat payload                 flow control
//   in_      in         in_battery_mv  [12:0] mV     in_valid / in_stall
//   out_     out        out_charge_pct [6:0] %       out_valid / out_stall
//
// One beat per cycle sustained while out_stall stays low; a beat goes from the input
// register through the lookup and multiply into the result register, and a stall can hold it
// in between. The single 8x14 multiply in the interpolator sets the path between the registers.
// rst_n is synchronous and clears both valid flags; payload registers are not reset.
// in_stall rises only when both registers hold a beat and out_stall is high.
module battery_level_from_voltage (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [bat_lvl_pkg::MV_W-1:0]  in_battery_mv,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [bat_lvl_pkg::LVL_W-1:0] out_charge_pct
);
  import bat_lvl_pkg::*;

  logic              in_vld_r;
  logic [MV_W-1:0]   mv_r;
  logic              out_vld_r;
  logic [LVL_W-1:0]  level_r;
  logic [LVL_W-1:0]  level_nxt;
  logic              out_free;
  seg_sel_t          sel;

  // Flow control
  assign out_free = !out_vld_r || !out_stall;
  assign in_stall = in_vld_r && !out_free;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (!in_stall) begin
      in_vld_r <= in_valid;
    end
    if (in_valid && !in_stall) begin
      mv_r <= in_battery_mv;
    end
  end

  bat_lvl_seg u_seg (
    .mv  (mv_r),
    .sel (sel)
  );

  bat_lvl_interp u_interp (
    .sel   (sel),
    .level (level_nxt)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_free) begin
      out_vld_r <= in_vld_r;
    end
    if (out_free && in_vld_r) begin
      level_r <= level_nxt;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_charge_pct = level_r;

`ifndef ASSERT_OFF
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (level_r <= CURVE_LVL[0]))
    else $error("level above full scale");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (in_vld_r && out_vld_r))
    else $error("input stalled with a free register");

  a_beat_taken: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_vld_r)
    else $error("accepted beat lost from input register");

  a_beat_moved: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && out_free) |=> (out_vld_r && level_r == $past(level_nxt)))
    else $error("beat not moved into result register");
`endif

endmodule

// ===== verif/level_checker.sv =====
// Checker for the battery level block: predicts each level and compares it at the result port.
`timescale 1ns / 1ps

module level_checker (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [bat_lvl_pkg::MV_W-1:0]  in_battery_mv,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [bat_lvl_pkg::LVL_W-1:0] out_charge_pct,
  output int                            errors,
  output int                            pending_levels,
  output int                            levels_checked,
  output int                            full_levels,
  output int                            empty_levels
);

  // Discharge curve knees, highest voltage first
  localparam int KNEES = 12;
  localparam int KNEE_MV [KNEES] = '{4200, 4100, 4000, 3920, 3850, 3780,
                                     3720, 3660, 3580, 3480, 3350, 3200};
  localparam int KNEE_LVL [KNEES] = '{100, 90, 80, 70, 60, 50,
                                      40, 30, 20, 10, 5, 0};

  typedef logic [bat_lvl_pkg::LVL_W-1:0] level_t;

  level_t expected_levels [$];

  // Level for one voltage: clamp at or above the top knee, zero below the bottom knee, else
  // interpolate in the first segment from the top that holds it, truncating the division
  function automatic level_t level_for_mv(input logic [bat_lvl_pkg::MV_W-1:0] mv);
    int v;
    int lvl;
    bit hit;
    v   = int'(mv);
    lvl = 0;
    hit = 1'b0;
    if (v >= KNEE_MV[0]) begin
      lvl = KNEE_LVL[0];
    end else begin
      for (int k = 0; k < KNEES - 1; k++) begin
        if (!hit && v <= KNEE_MV[k] && v >= KNEE_MV[k+1]) begin
          hit = 1'b1;
          lvl = KNEE_LVL[k+1] + ((v - KNEE_MV[k+1]) * (KNEE_LVL[k] - KNEE_LVL[k+1]))
                / (KNEE_MV[k] - KNEE_MV[k+1]);
        end
      end
    end
    return level_t'(lvl);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    errors++;
  endtask

  // Result beats are checked before input beats are queued, so a spurious
  // result can never pair with a voltage taken on the same edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_levels.size() == 0) begin
          report_mismatch($sformatf("charge %0d with no voltage outstanding",
                                    out_charge_pct));
        end else begin
          level_t want;
          want = expected_levels.pop_front();
          levels_checked++;
          if (want == 100) full_levels++;
          if (want == 0) empty_levels++;
          if (out_charge_pct !== want)
            report_mismatch($sformatf("charge_pct %0d, expected %0d",
                                      out_charge_pct, want));
        end
      end
      if (in_valid && !in_stall)
        expected_levels.push_back(level_for_mv(in_battery_mv));
      pending_levels = expected_levels.size();
    end
  end

endmodule

// ===== verif/battery_level_from_voltage_tb.sv =====
// Testbench top for the battery level block: stimulus, flow control, watchdog and verdict.
`timescale 1ns / 1ps

module battery_level_from_voltage_tb;

  localparam int RANDOM_BEATS = 630;   // per idling phase
  localparam int STALL_LIMIT  = 2000;  // cycles without any beat before giving up
  localparam int TAIL_CYCLES  = 8;

  typedef logic [bat_lvl_pkg::MV_W-1:0] mv_t;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [bat_lvl_pkg::MV_W-1:0]  in_battery_mv = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic [bat_lvl_pkg::LVL_W-1:0] out_charge_pct;

  int errors;
  int pending_levels;
  int levels_checked;
  int full_levels;
  int empty_levels;

  int tx_gap_pct  = 0;
  int rx_hold_pct = 0;
  int sent_beats  = 0;
  int drains      = 0;
  int quiet_cycles = 0;

  battery_level_from_voltage u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_battery_mv  (in_battery_mv),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_charge_pct (out_charge_pct)
  );

  level_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_battery_mv  (in_battery_mv),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_charge_pct (out_charge_pct),
    .errors         (errors),
    .pending_levels (pending_levels),
    .levels_checked (levels_checked),
    .full_levels    (full_levels),
    .empty_levels   (empty_levels)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver back-pressure
  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < rx_hold_pct);
  end

  // Watchdog: no beat on either channel for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no beat for %0d cycles", STALL_LIMIT);
        $display("DONE: errors detected");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // One voltage beat, with random idle cycles ahead of it; returns at a falling edge
  task automatic send_beat(input logic [bat_lvl_pkg::MV_W-1:0] mv);
    while ($urandom_range(99) < tx_gap_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_battery_mv <= mv;
    do @(posedge clk); while (in_stall);
    sent_beats++;
    @(negedge clk);
  endtask

  // Hold the sender until every queued level has come back
  task automatic drain;
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_levels != 0) @(negedge clk);
    drains++;
  endtask

  // Mostly voltages across the curve, some within 1 mV of a knee, the rest anywhere
  function automatic logic [bat_lvl_pkg::MV_W-1:0] random_mv;
    int pick;
    int knee;
    pick = $urandom_range(99);
    if (pick < 70) begin
      return mv_t'($urandom_range(4250, 3150));
    end else if (pick < 82) begin
      knee = int'(bat_lvl_pkg::CURVE_MV[$urandom_range(bat_lvl_pkg::CURVE_N - 1, 0)]);
      return mv_t'(knee + int'($urandom_range(2, 0)) - 1);
    end else begin
      return mv_t'($urandom_range(8191, 0));
    end
  endfunction

  initial begin
    logic [bat_lvl_pkg::MV_W-1:0] edge_mv [11];
    edge_mv = '{13'd0, 13'd8191, 13'd4201, 13'd4199, 13'd3199, 13'd3201,
                13'd3349, 13'd3351, 13'd3415, 13'd4150, 13'd5000};

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: every knee, both clamps, just off the ends and mid-segment
    for (int k = 0; k < bat_lvl_pkg::CURVE_N; k++)
      send_beat(bat_lvl_pkg::CURVE_MV[k]);
    foreach (edge_mv[k])
      send_beat(edge_mv[k]);
    drain();

    // Random, in three idling mixes
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin tx_gap_pct = 26; rx_hold_pct = 52; end
        1: begin tx_gap_pct = 52; rx_hold_pct = 26; end
        default: begin tx_gap_pct = 0; rx_hold_pct = 0; end
      endcase
      for (int i = 0; i < RANDOM_BEATS; i++) begin
        if (i == RANDOM_BEATS / 2) drain();
        send_beat(random_mv());
      end
      drain();
    end

    in_valid <= 1'b0;
    while (pending_levels != 0) @(negedge clk);
    repeat (TAIL_CYCLES) @(negedge clk);

    $display("Sent %0d voltage beats; %0d levels checked, %0d full and %0d empty.",
             sent_beats, levels_checked, full_levels, empty_levels);
    $display("Idle mixes sender/receiver 26/52, 52/26 and none; pipe drained %0d times.",
             drains);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
